@@ sv/jpd_pkg.sv @@
// Shared types and constants for the joystick packet deframer.
package jpd_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'hFF;
    localparam logic [7:0] GOOD_SUM   = 8'hFF;
    localparam int         HOLD_SLOTS = 6;
    localparam int         SLOT_BTN   = 4;

    // configuration register indexes
    localparam logic REG_GUN_MASK   = 1'b0;
    localparam logic REG_LASER_MASK = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SKIP    = 2'd1,
        PH_COLLECT = 2'd2
    } t_phase;

    typedef struct packed {
        logic                             echo_valid;
        logic [7:0]                       echo_byte;
        logic                             packet_done;
        logic                             checksum_good;
        logic                             gun_flag;
        logic                             laser_flag;
        logic [HOLD_SLOTS-1:0][7:0]       slots;
    } t_result;

endpackage

@@ sv/jpd_core.sv @@
// Deframer state: sync hunt, packet collection, checksum and held flags.
module jpd_core #(
    parameter int PACKET_BYTES = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_rx_byte,
    input  logic [7:0]         i_gun_mask,
    input  logic [7:0]         i_laser_mask,
    output jpd_pkg::t_result   o_result
);

    localparam int CNT_W = $clog2(PACKET_BYTES + 1);

    jpd_pkg::t_phase                              r_phase, n_phase;
    logic [CNT_W-1:0]                             r_count, n_count;
    logic [7:0]                                   r_sum, n_sum;
    logic [jpd_pkg::HOLD_SLOTS-1:0][7:0]          r_slots, n_slots;
    logic                                         r_gun, n_gun;
    logic                                         r_laser, n_laser;

    logic [CNT_W-1:0] count_inc;
    logic [7:0]       sum_inc;
    logic             valid, done, good;

    assign count_inc = r_count + 1'b1;
    assign sum_inc   = r_sum + i_rx_byte;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_sum   = r_sum;
        n_slots = r_slots;
        n_gun   = r_gun;
        n_laser = r_laser;
        valid   = 1'b0;
        done    = 1'b0;
        good    = 1'b0;
        unique case (r_phase)
            jpd_pkg::PH_HUNT: begin
                if (i_rx_byte == jpd_pkg::SYNC_BYTE) begin
                    n_phase = jpd_pkg::PH_SKIP;
                    n_count = '0;
                    n_sum   = '0;
                    valid   = 1'b1;
                end
            end
            jpd_pkg::PH_SKIP: begin
                valid      = 1'b1;
                n_slots[0] = i_rx_byte;
                if (i_rx_byte != jpd_pkg::SYNC_BYTE) begin
                    n_sum   = sum_inc;
                    n_count = CNT_W'(1);
                    n_phase = jpd_pkg::PH_COLLECT;
                end
            end
            jpd_pkg::PH_COLLECT: begin
                valid = 1'b1;
                for (int k = 0; k < jpd_pkg::HOLD_SLOTS; k++) begin
                    if (int'(r_count) == k) begin
                        n_slots[k] = i_rx_byte;
                    end
                end
                n_sum   = sum_inc;
                n_count = count_inc;
                if (count_inc >= CNT_W'(PACKET_BYTES)) begin
                    done = 1'b1;
                    good = (sum_inc == jpd_pkg::GOOD_SUM);
                    // button byte may be the one arriving now
                    if (good) begin
                        n_gun   = |(n_slots[jpd_pkg::SLOT_BTN] & i_gun_mask);
                        n_laser = |(n_slots[jpd_pkg::SLOT_BTN] & i_laser_mask);
                    end
                    n_phase = jpd_pkg::PH_HUNT;
                    n_count = '0;
                end
            end
            default: begin
                n_phase = jpd_pkg::PH_HUNT;
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jpd_pkg::PH_HUNT;
            r_count <= '0;
            r_sum   <= '0;
            r_slots <= '0;
            r_gun   <= 1'b0;
            r_laser <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_slots <= n_slots;
            r_gun   <= n_gun;
            r_laser <= n_laser;
        end
    end

    always_comb begin
        o_result.echo_valid    = valid;
        o_result.echo_byte     = i_rx_byte;
        o_result.packet_done   = done;
        o_result.checksum_good = good;
        o_result.gun_flag      = n_gun;
        o_result.laser_flag    = n_laser;
        o_result.slots         = n_slots;
    end

endmodule

@@ sv/joystick_packet_deframer_unit.sv @@
// Joystick packet deframer top level: input register, deframer core, result register.
// One received byte per transaction, one result per byte. A byte accepted into the input
// register passes the deframer core into the result register when that is free or taken.
// The state update (a few compares and one 8-bit add) is combinational, so a new byte can
// be taken every cycle while results drain. While a finished result waits for i_ready,
// the input register takes one more byte and then o_ready drops until the result is taken.
// The mask registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must
// do so only while no transaction is in flight, which the block itself does not enforce.
module joystick_packet_deframer_unit #(
    parameter int PACKET_BYTES = 7
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_echo_valid,
    output logic [7:0] o_echo_byte,
    output logic       o_packet_done,
    output logic       o_checksum_good,
    output logic       o_gun_flag,
    output logic       o_laser_flag,
    output logic [7:0] o_right_horizontal,
    output logic [7:0] o_right_vertical,
    output logic [7:0] o_left_horizontal,
    output logic [7:0] o_left_vertical,
    output logic [7:0] o_button_bits,
    output logic [7:0] o_extra_byte,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    jpd_pkg::t_result r_out;
    logic [7:0]       r_gun_mask;
    logic [7:0]       r_laser_mask;
    logic             advance;
    jpd_pkg::t_result core_result;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gun_mask   <= 8'h20;
            r_laser_mask <= 8'h08;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                jpd_pkg::REG_GUN_MASK:   r_gun_mask   <= i_cfg_data;
                jpd_pkg::REG_LASER_MASK: r_laser_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    jpd_core #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_rx_byte    (r_in_byte),
        .i_gun_mask   (r_gun_mask),
        .i_laser_mask (r_laser_mask),
        .o_result     (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_echo_valid       = r_out.echo_valid;
    assign o_echo_byte        = r_out.echo_byte;
    assign o_packet_done      = r_out.packet_done;
    assign o_checksum_good    = r_out.checksum_good;
    assign o_gun_flag         = r_out.gun_flag;
    assign o_laser_flag       = r_out.laser_flag;
    assign o_right_horizontal = r_out.slots[0];
    assign o_right_vertical   = r_out.slots[1];
    assign o_left_horizontal  = r_out.slots[2];
    assign o_left_vertical    = r_out.slots[3];
    assign o_button_bits      = r_out.slots[4];
    assign o_extra_byte       = r_out.slots[5];

endmodule
